[rtl/i2crs_pkg.sv]
// shared types and constants for the i2c register slave
`default_nettype none

package i2crs_pkg;

  localparam int unsigned DATA_W = 8;
  localparam int unsigned ADDR_W = 7;
  localparam int unsigned CNT_W  = 4;
  localparam int unsigned IDX_W  = 8;

  localparam logic [DATA_W-1:0] MSB_MASK = 8'h80;
  localparam logic [CNT_W-1:0]  BYTE_BITS = 4'd8;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_DEVICE_ADDRESS = 8'd0;
  localparam logic [IDX_W-1:0] REG_REGISTER_COUNT = 8'd1;

  // event kinds
  localparam logic [1:0] EV_WRITE     = 2'd0;
  localparam logic [1:0] EV_READ      = 2'd1;
  localparam logic [1:0] EV_BAD_REG   = 2'd2;
  localparam logic [1:0] EV_BAD_ADDR  = 2'd3;

  localparam logic [ADDR_W-1:0] DEVICE_ADDRESS_RESET = 7'd32;
  localparam logic [DATA_W-1:0] REGISTER_COUNT_RESET = 8'd16;

  typedef enum logic [13:0] {
    PH_IDLE     = 14'h0001,
    PH_ARMED    = 14'h0002,
    PH_START    = 14'h0004,
    PH_ADDR     = 14'h0008,
    PH_ACK_AW   = 14'h0010,
    PH_REG      = 14'h0020,
    PH_NACK_REG = 14'h0040,
    PH_ACK_REG  = 14'h0080,
    PH_DATA     = 14'h0100,
    PH_RESTART  = 14'h0200,
    PH_ACK_DATA = 14'h0400,
    PH_ACK_AR   = 14'h0800,
    PH_TX       = 14'h1000,
    PH_READ_ACK = 14'h2000
  } phase_t;

  typedef struct packed {
    logic              scl;
    logic              sda;
    logic [DATA_W-1:0] read_value;
  } in_t;

  typedef struct packed {
    logic              sda_release;
    logic              event_valid;
    logic [1:0]        event_kind;
    logic [DATA_W-1:0] event_register;
    logic [DATA_W-1:0] event_value;
    logic [DATA_W-1:0] selected_register;
  } out_t;

  typedef struct packed {
    logic [ADDR_W-1:0] device_address;
    logic [DATA_W-1:0] register_count;
  } cfg_t;

endpackage

`default_nettype wire

[rtl/i2crs_core.sv]
// bus tracking state machine, one sample per step
`default_nettype none

module i2crs_core (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           step,
  input  wire i2crs_pkg::in_t  word,
  input  wire i2crs_pkg::cfg_t cfg,
  output i2crs_pkg::out_t     result
);

  i2crs_pkg::phase_t phase, phase_next;
  logic [i2crs_pkg::CNT_W-1:0]  bit_count, bit_count_next;
  logic [i2crs_pkg::DATA_W-1:0] receive_shift, receive_shift_next;
  logic [i2crs_pkg::DATA_W-1:0] transmit_shift, transmit_shift_next;
  logic [i2crs_pkg::DATA_W-1:0] current_register, current_register_next;
  logic previous_scl;
  logic data_drive, data_drive_next;

  logic rise, fall;
  logic [i2crs_pkg::DATA_W-1:0] wr_addr, rd_addr;
  logic ev;
  logic [1:0] kind;
  logic [i2crs_pkg::DATA_W-1:0] ereg, eval;

  assign rise    = word.scl & ~previous_scl;
  assign fall    = ~word.scl & previous_scl;
  assign wr_addr = {cfg.device_address, 1'b0};
  assign rd_addr = {cfg.device_address, 1'b1};

  always_comb begin
    phase_next            = phase;
    bit_count_next        = bit_count;
    receive_shift_next    = receive_shift;
    transmit_shift_next   = transmit_shift;
    current_register_next = current_register;
    data_drive_next       = data_drive;
    ev   = 1'b0;
    kind = i2crs_pkg::EV_WRITE;
    ereg = '0;
    eval = '0;
    unique case (phase)
      i2crs_pkg::PH_IDLE: begin
        if (word.scl && word.sda) phase_next = i2crs_pkg::PH_ARMED;
      end
      i2crs_pkg::PH_ARMED: begin
        if (!word.scl) phase_next = i2crs_pkg::PH_IDLE;
        else if (!word.sda) phase_next = i2crs_pkg::PH_START;
      end
      i2crs_pkg::PH_START: begin
        if (word.sda) begin
          phase_next = i2crs_pkg::PH_IDLE;
        end else if (!word.scl) begin
          phase_next          = i2crs_pkg::PH_ADDR;
          bit_count_next      = '0;
          receive_shift_next  = '0;
          transmit_shift_next = '0;
        end
      end
      i2crs_pkg::PH_ADDR, i2crs_pkg::PH_REG, i2crs_pkg::PH_DATA: begin
        if (rise && bit_count < i2crs_pkg::BYTE_BITS) begin
          receive_shift_next = {receive_shift[i2crs_pkg::DATA_W-2:0], word.sda};
          bit_count_next     = bit_count + 4'd1;
        end else if (phase == i2crs_pkg::PH_DATA && word.scl && previous_scl &&
                     !word.sda && bit_count == 4'd1 && receive_shift == 8'd1) begin
          phase_next = i2crs_pkg::PH_RESTART;
        end else if (fall && bit_count >= i2crs_pkg::BYTE_BITS) begin
          if (phase == i2crs_pkg::PH_ADDR) begin
            if (receive_shift == wr_addr) begin
              data_drive_next = 1'b0;
              phase_next      = i2crs_pkg::PH_ACK_AW;
            end else if (receive_shift == rd_addr) begin
              data_drive_next = 1'b0;
              phase_next      = i2crs_pkg::PH_ACK_AR;
            end else begin
              ev         = 1'b1;
              kind       = i2crs_pkg::EV_BAD_ADDR;
              phase_next = i2crs_pkg::PH_IDLE;
            end
          end else if (phase == i2crs_pkg::PH_REG) begin
            if (receive_shift >= cfg.register_count) begin
              data_drive_next = 1'b1;
              phase_next      = i2crs_pkg::PH_NACK_REG;
            end else begin
              current_register_next = receive_shift;
              data_drive_next       = 1'b0;
              phase_next            = i2crs_pkg::PH_ACK_REG;
            end
          end else begin
            data_drive_next = 1'b0;
            phase_next      = i2crs_pkg::PH_ACK_DATA;
          end
        end
      end
      i2crs_pkg::PH_RESTART: begin
        if (!word.scl) begin
          phase_next          = i2crs_pkg::PH_ADDR;
          bit_count_next      = '0;
          receive_shift_next  = '0;
          transmit_shift_next = '0;
        end
      end
      i2crs_pkg::PH_ACK_AW: begin
        if (fall) begin
          data_drive_next    = 1'b1;
          phase_next         = i2crs_pkg::PH_REG;
          bit_count_next     = '0;
          receive_shift_next = '0;
        end
      end
      i2crs_pkg::PH_NACK_REG: begin
        if (fall) begin
          data_drive_next = 1'b1;
          ev              = 1'b1;
          kind            = i2crs_pkg::EV_BAD_REG;
          ereg            = receive_shift;
          phase_next      = i2crs_pkg::PH_IDLE;
        end
      end
      i2crs_pkg::PH_ACK_REG: begin
        if (fall) begin
          data_drive_next    = 1'b1;
          phase_next         = i2crs_pkg::PH_DATA;
          bit_count_next     = '0;
          receive_shift_next = '0;
        end
      end
      i2crs_pkg::PH_ACK_DATA: begin
        if (fall) begin
          data_drive_next = 1'b1;
          ev              = 1'b1;
          kind            = i2crs_pkg::EV_WRITE;
          ereg            = current_register;
          eval            = receive_shift;
          phase_next      = i2crs_pkg::PH_IDLE;
        end
      end
      i2crs_pkg::PH_ACK_AR: begin
        if (rise) begin
          transmit_shift_next = word.read_value;
          receive_shift_next  = word.read_value;
        end else if (fall) begin
          data_drive_next = (transmit_shift & i2crs_pkg::MSB_MASK) != '0;
          phase_next      = i2crs_pkg::PH_TX;
          bit_count_next  = '0;
        end
      end
      i2crs_pkg::PH_TX: begin
        if (rise && bit_count < i2crs_pkg::BYTE_BITS) begin
          transmit_shift_next = {transmit_shift[i2crs_pkg::DATA_W-2:0], 1'b0};
          bit_count_next      = bit_count + 4'd1;
        end else if (fall) begin
          if (bit_count >= i2crs_pkg::BYTE_BITS) begin
            data_drive_next = 1'b1;
            phase_next      = i2crs_pkg::PH_READ_ACK;
          end else begin
            data_drive_next = (transmit_shift & i2crs_pkg::MSB_MASK) != '0;
          end
        end
      end
      i2crs_pkg::PH_READ_ACK: begin
        if (fall) begin
          data_drive_next = 1'b1;
          ev              = 1'b1;
          kind            = i2crs_pkg::EV_READ;
          ereg            = current_register;
          eval            = receive_shift;
          phase_next      = i2crs_pkg::PH_IDLE;
        end
      end
      default: begin
        data_drive_next = 1'b1;
        phase_next      = i2crs_pkg::PH_IDLE;
      end
    endcase
  end

  always_comb begin
    result.sda_release       = data_drive_next;
    result.event_valid       = ev;
    result.event_kind        = kind;
    result.event_register    = ereg;
    result.event_value       = eval;
    result.selected_register = current_register_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= i2crs_pkg::PH_IDLE;
      bit_count        <= '0;
      receive_shift    <= '0;
      transmit_shift   <= '0;
      current_register <= '0;
      previous_scl     <= 1'b1;
      data_drive       <= 1'b1;
    end else if (step) begin
      phase            <= phase_next;
      bit_count        <= bit_count_next;
      receive_shift    <= receive_shift_next;
      transmit_shift   <= transmit_shift_next;
      current_register <= current_register_next;
      previous_scl     <= word.scl;
      data_drive       <= data_drive_next;
    end
  end

  a_event_ends_in_idle: assert property (@(posedge clk) disable iff (rst)
    step && result.event_valid |=> phase == i2crs_pkg::PH_IDLE)
    else $error("event did not return to idle");

  a_bit_count_range: assert property (@(posedge clk) disable iff (rst)
    bit_count <= i2crs_pkg::BYTE_BITS)
    else $error("bit count past one byte");

  a_drive_only_when_owned: assert property (@(posedge clk) disable iff (rst)
    !data_drive |-> (phase == i2crs_pkg::PH_ACK_AW || phase == i2crs_pkg::PH_ACK_REG ||
                     phase == i2crs_pkg::PH_ACK_DATA || phase == i2crs_pkg::PH_ACK_AR ||
                     phase == i2crs_pkg::PH_TX))
    else $error("sda pulled low outside acknowledge or transmit");

  a_wrong_addr_clean: assert property (@(posedge clk) disable iff (rst)
    result.event_valid && result.event_kind == i2crs_pkg::EV_BAD_ADDR |->
      result.event_register == '0 && result.event_value == '0)
    else $error("wrong address event carries data");

endmodule

`default_nettype wire

[rtl/i2c_register_slave.sv]
// top level of the i2c register slave with config port and output skid buffer
//
// in channel: one oversampled scl/sda sample plus read_value per word, taken
// when in_valid and in_ready are both high. out channel: exactly one result
// word per input word, in order, with the released/driven sda level after
// that sample, any finished transaction event and the selected register.
// each result word is registered into the output register, or into the skid
// register on a stall. throughput: one sample per cycle while out_ready stays high;
// the state update is a single pass through the bus state machine.
// stalls: a two entry output stage (output register plus skid register)
// lets one more sample be taken after out_ready drops; in_ready falls only
// once the skid register is full and rises as soon as it drains.
// config: cfg_index 0 writes device_address (7 bits), 1 writes
// register_count; other indexes are ignored. cfg_ready is always high.
// reset: synchronous; the bus tracker goes idle with sda released,
// device_address returns to 32 and register_count to 16, and both output
// entries are emptied.
`default_nettype none

module i2c_register_slave (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire i2crs_pkg::in_t                  in_word,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output i2crs_pkg::out_t                      out_word,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [i2crs_pkg::IDX_W-1:0]     cfg_index,
  input  wire logic [i2crs_pkg::DATA_W-1:0]    cfg_data
);

  i2crs_pkg::cfg_t cfg;
  i2crs_pkg::out_t result;
  i2crs_pkg::out_t skid_word;
  logic skid_valid;
  logic step;

  assign cfg_ready = 1'b1;
  assign in_ready  = ~skid_valid;
  assign step      = in_valid & in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.device_address <= i2crs_pkg::DEVICE_ADDRESS_RESET;
      cfg.register_count <= i2crs_pkg::REGISTER_COUNT_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == i2crs_pkg::REG_DEVICE_ADDRESS) begin
        cfg.device_address <= cfg_data[i2crs_pkg::ADDR_W-1:0];
      end else if (cfg_index == i2crs_pkg::REG_REGISTER_COUNT) begin
        cfg.register_count <= cfg_data;
      end
    end
  end

  i2crs_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .word   (in_word),
    .cfg    (cfg),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_word   <= skid_word;
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else if (step) begin
        out_word  <= result;
        out_valid <= 1'b1;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (step) begin
      skid_word  <= result;
      skid_valid <= 1'b1;
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held with empty output register");

  a_stall_fills_skid: assert property (@(posedge clk) disable iff (rst)
    step && out_valid && !out_ready |=> skid_valid)
    else $error("accepted sample lost during stall");

  a_no_accept_when_full: assert property (@(posedge clk) disable iff (rst)
    skid_valid && out_valid && !out_ready |=> skid_valid && $stable(skid_word))
    else $error("skid entry changed while stalled");

endmodule

`default_nettype wire
